### rtl/aabbcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AABB collision response package
// Widths, register and axis codes, and the saturation helper shared by the
// collision response block and its checker.
// ----------------------------------------------------------------------------
package aabbcr_pkg;

    localparam int unsigned NUM_AXES   = 3;
    localparam int unsigned COORD_W    = 32;
    localparam int unsigned HALF_W     = 31;
    localparam int unsigned REST_W     = 9;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 31;

    // Room for 2*pos - min - max and for pos plus or minus an overlap.
    localparam int unsigned WIDE_W     = 35;
    // Product of a 32 bit signed velocity and a 9 bit unsigned factor.
    localparam int unsigned PROD_W     = 41;
    localparam int unsigned REST_SHIFT = 8;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [WIDE_W-1:0]  wide_t;
    typedef logic signed [PROD_W-1:0]  prod_t;

    typedef enum logic [1:0] {
        AXIS_NONE = 2'd0,
        AXIS_X    = 2'd1,
        AXIS_Y    = 2'd2,
        AXIS_Z    = 2'd3
    } axis_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HALF_X      = 2'd0,
        REG_HALF_Y      = 2'd1,
        REG_HALF_Z      = 2'd2,
        REG_RESTITUTION = 2'd3
    } cfg_reg_t;

    // Clamp a wide signed value to the 32 bit signed range.
    function automatic coord_t sat_coord(input wide_t v);
        coord_t res;
        if (v[WIDE_W-1:COORD_W-1] == {(WIDE_W-COORD_W+1){v[WIDE_W-1]}})
        begin
            res = v[COORD_W-1:0];
        end
        else if (v[WIDE_W-1])
        begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

### rtl/aabb_collision_response.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AABB collision response
// Resolves one body box against one obstacle box per word: picks the axis
// of least penetration, pushes the body out and reflects its velocity.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one word per query: obstacle corners, body
//   position and body velocity, all signed Q16.16. A word is taken at a
//   rising edge with in_valid high and in_stall low. The output channel
//   presents the resolved position and velocity plus hit and contact_axis;
//   a word leaves at an edge with out_valid high and out_stall low.
//   The block is a two register pipeline: the query is captured in an
//   input register, the whole response is computed in one combinational
//   pass and captured in the result register. One query per clock is
//   sustained while the receiver does not stall.
//   When the receiver stalls, the result register holds its word steady;
//   one more query can still be taken into the input register, after which
//   in_stall rises until the output drains.
//   Reset (rst_n low) empties both registers and loads the half extents
//   with 1.0 and restitution with 102/256. Configuration writes are always
//   ready and should only be issued while the pipeline is empty.
// ----------------------------------------------------------------------------
module aabb_collision_response
(
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [aabbcr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [aabbcr_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [aabbcr_pkg::COORD_W-1:0]  box_min_x,
    input  logic signed [aabbcr_pkg::COORD_W-1:0]  box_min_y,
    input  logic signed [aabbcr_pkg::COORD_W-1:0]  box_min_z,
    input  logic signed [aabbcr_pkg::COORD_W-1:0]  box_max_x,
    input  logic signed [aabbcr_pkg::COORD_W-1:0]  box_max_y,
    input  logic signed [aabbcr_pkg::COORD_W-1:0]  box_max_z,
    input  logic signed [aabbcr_pkg::COORD_W-1:0]  pos_x,
    input  logic signed [aabbcr_pkg::COORD_W-1:0]  pos_y,
    input  logic signed [aabbcr_pkg::COORD_W-1:0]  pos_z,
    input  logic signed [aabbcr_pkg::COORD_W-1:0]  vel_x,
    input  logic signed [aabbcr_pkg::COORD_W-1:0]  vel_y,
    input  logic signed [aabbcr_pkg::COORD_W-1:0]  vel_z,

    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [aabbcr_pkg::COORD_W-1:0]  new_pos_x,
    output logic signed [aabbcr_pkg::COORD_W-1:0]  new_pos_y,
    output logic signed [aabbcr_pkg::COORD_W-1:0]  new_pos_z,
    output logic signed [aabbcr_pkg::COORD_W-1:0]  new_vel_x,
    output logic signed [aabbcr_pkg::COORD_W-1:0]  new_vel_y,
    output logic signed [aabbcr_pkg::COORD_W-1:0]  new_vel_z,
    output logic                                   hit,
    output logic [1:0]                             contact_axis
);

    import aabbcr_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always accepted.
    // ------------------------------------------------------------------
    logic [HALF_W-1:0] half_reg [NUM_AXES];
    logic [REST_W-1:0] rest_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg[0] <= HALF_W'(65536);
            half_reg[1] <= HALF_W'(65536);
            half_reg[2] <= HALF_W'(65536);
            rest_reg    <= REST_W'(102);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_HALF_X:      half_reg[0] <= cfg_data[HALF_W-1:0];
                REG_HALF_Y:      half_reg[1] <= cfg_data[HALF_W-1:0];
                REG_HALF_Z:      half_reg[2] <= cfg_data[HALF_W-1:0];
                REG_RESTITUTION: rest_reg    <= cfg_data[REST_W-1:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The input register advances whenever it is empty, or the
    // result register is empty or is being drained this cycle.
    // ------------------------------------------------------------------
    logic in_valid_reg;
    logic out_valid_reg;
    logic in_load;
    logic out_load;

    assign in_stall  = in_valid_reg && out_valid_reg && out_stall;
    assign in_load   = in_valid && !in_stall;
    assign out_load  = in_valid_reg && !(out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input register, one entry per axis.
    // ------------------------------------------------------------------
    coord_t bmin_reg [NUM_AXES];
    coord_t bmax_reg [NUM_AXES];
    coord_t pos_reg  [NUM_AXES];
    coord_t vel_reg  [NUM_AXES];

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            bmin_reg[0] <= box_min_x;
            bmin_reg[1] <= box_min_y;
            bmin_reg[2] <= box_min_z;
            bmax_reg[0] <= box_max_x;
            bmax_reg[1] <= box_max_y;
            bmax_reg[2] <= box_max_z;
            pos_reg[0]  <= pos_x;
            pos_reg[1]  <= pos_y;
            pos_reg[2]  <= pos_z;
            vel_reg[0]  <= vel_x;
            vel_reg[1]  <= vel_y;
            vel_reg[2]  <= vel_z;
        end
    end

    // ------------------------------------------------------------------
    // Per axis: strict overlap test, penetration depth, center offset,
    // pushed-out position and reflected velocity. The three axes are
    // independent, so the velocity products run in parallel with the
    // axis choice and are simply selected afterwards.
    // ------------------------------------------------------------------
    wide_t  p_w      [NUM_AXES];
    wide_t  h_w      [NUM_AXES];
    wide_t  lo_w     [NUM_AXES];
    wide_t  hi_w     [NUM_AXES];
    wide_t  dif      [NUM_AXES];
    wide_t  ov       [NUM_AXES];
    wide_t  push_pos [NUM_AXES];
    prod_t  prod     [NUM_AXES];
    prod_t  quot     [NUM_AXES];
    wide_t  refl_vel [NUM_AXES];
    logic   ov_ok    [NUM_AXES];

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            p_w[i]  = WIDE_W'(pos_reg[i]);
            h_w[i]  = wide_t'({{(WIDE_W-HALF_W){1'b0}}, half_reg[i]});
            lo_w[i] = WIDE_W'(bmin_reg[i]);
            hi_w[i] = WIDE_W'(bmax_reg[i]);

            ov_ok[i] = ((p_w[i] - h_w[i]) < hi_w[i]) && ((p_w[i] + h_w[i]) > lo_w[i]);

            dif[i] = (p_w[i] <<< 1) - lo_w[i] - hi_w[i];
            if (dif[i][WIDE_W-1])
            begin
                ov[i] = p_w[i] + h_w[i] - lo_w[i];
            end
            else
            begin
                ov[i] = hi_w[i] - p_w[i] + h_w[i];
            end
            push_pos[i] = dif[i][WIDE_W-1] ? (p_w[i] - ov[i]) : (p_w[i] + ov[i]);

            // Velocity times restitution, divided by 256 toward zero.
            prod[i] = PROD_W'(vel_reg[i]) * prod_t'({{(PROD_W-REST_W){1'b0}}, rest_reg});
            if (prod[i][PROD_W-1])
            begin
                quot[i] = (prod[i] + prod_t'((1 << REST_SHIFT) - 1)) >>> REST_SHIFT;
            end
            else
            begin
                quot[i] = prod[i] >>> REST_SHIFT;
            end
            refl_vel[i] = wide_t'(-quot[i]);
        end
    end

    // Least penetration wins; ties fall through to the later axis.
    logic  hit_c;
    axis_t axis_c;

    always_comb
    begin
        hit_c = ov_ok[0] && ov_ok[1] && ov_ok[2];
        if (!hit_c)
        begin
            axis_c = AXIS_NONE;
        end
        else if ((ov[0] < ov[1]) && (ov[0] < ov[2]))
        begin
            axis_c = AXIS_X;
        end
        else if (ov[1] < ov[2])
        begin
            axis_c = AXIS_Y;
        end
        else
        begin
            axis_c = AXIS_Z;
        end
    end

    // Apply the response on the chosen axis only. A zero center offset
    // leaves that axis untouched even though a hit is reported.
    coord_t npos_c [NUM_AXES];
    coord_t nvel_c [NUM_AXES];
    logic   apply  [NUM_AXES];

    always_comb
    begin
        apply[0] = (axis_c == AXIS_X);
        apply[1] = (axis_c == AXIS_Y);
        apply[2] = (axis_c == AXIS_Z);
        for (int i = 0; i < NUM_AXES; i++)
        begin
            if (apply[i] && (dif[i] != '0))
            begin
                npos_c[i] = sat_coord(push_pos[i]);
                nvel_c[i] = sat_coord(refl_vel[i]);
            end
            else
            begin
                npos_c[i] = pos_reg[i];
                nvel_c[i] = vel_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    coord_t npos_reg [NUM_AXES];
    coord_t nvel_reg [NUM_AXES];
    logic   hit_reg;
    axis_t  axis_reg;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                npos_reg[i] <= npos_c[i];
                nvel_reg[i] <= nvel_c[i];
            end
            hit_reg  <= hit_c;
            axis_reg <= axis_c;
        end
    end

    assign new_pos_x    = npos_reg[0];
    assign new_pos_y    = npos_reg[1];
    assign new_pos_z    = npos_reg[2];
    assign new_vel_x    = nvel_reg[0];
    assign new_vel_y    = nvel_reg[1];
    assign new_vel_z    = nvel_reg[2];
    assign hit          = hit_reg;
    assign contact_axis = axis_reg;

endmodule

### rtl/aabbcr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AABB collision response checker
// Port-level assertions on the collision response block, bound to it.
// ----------------------------------------------------------------------------
module aabbcr_checker
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_stall,
    input  logic                                   out_valid,
    input  logic                                   out_stall,
    input  logic signed [aabbcr_pkg::COORD_W-1:0]  new_pos_x,
    input  logic signed [aabbcr_pkg::COORD_W-1:0]  new_pos_y,
    input  logic signed [aabbcr_pkg::COORD_W-1:0]  new_pos_z,
    input  logic signed [aabbcr_pkg::COORD_W-1:0]  new_vel_x,
    input  logic signed [aabbcr_pkg::COORD_W-1:0]  new_vel_y,
    input  logic signed [aabbcr_pkg::COORD_W-1:0]  new_vel_z,
    input  logic                                   hit,
    input  logic [1:0]                             contact_axis
);

    import aabbcr_pkg::*;

    // A stalled result word holds still.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(new_pos_x) && $stable(new_pos_y)
            && $stable(new_pos_z) && $stable(new_vel_x) && $stable(new_vel_y)
            && $stable(new_vel_z) && $stable(hit) && $stable(contact_axis))
        else $error("result word changed while stalled");

    // Input backpressure only arises from a full, stalled output.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // A word taken into an empty pipe reaches the output via the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> ##1 out_valid)
        else $error("result did not appear with the expected latency");

    // A miss reports no axis, a hit always names one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> contact_axis == AXIS_NONE)
        else $error("axis reported without a hit");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> contact_axis != AXIS_NONE)
        else $error("hit reported without an axis");

endmodule

bind aabb_collision_response aabbcr_checker u_aabbcr_checker (.*);
